// ===== sv/gapless_grid_tile_placer_core_defines.svh =====
// Assertion macros for the gapless grid tile placer checker.
// Included by the checker file only; depends on nothing else.
`ifndef GAPLESS_GRID_TILE_PLACER_CORE_DEFINES_SVH
`define GAPLESS_GRID_TILE_PLACER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GGTP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggtp check failed");

// Next-cycle implication, disabled while reset is high.
`define GGTP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggtp check failed");

`endif

// ===== sv/ggtp_pkg.sv =====
// Shared types, constants and functions of the gapless grid tile placer.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none
package ggtp_pkg;

   localparam int CsrIndexWidth = 2;
   localparam logic [6:0] MaxWindows = 7'd64;
   localparam logic [15:0] AreaWidthReset = 16'd1920;
   localparam logic [15:0] AreaHeightReset = 16'd1080;
   localparam logic [4:0] DivSteps = 5'd16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_AREA_X      = 2'd0,
      CSR_AREA_Y      = 2'd1,
      CSR_AREA_WIDTH  = 2'd2,
      CSR_AREA_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ROWS,
      ST_PITCH,
      ST_WIN,
      ST_CH_GO,
      ST_CH,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_ROWS,
      DIV_PITCH,
      DIV_WIN,
      DIV_CH
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clear_pass;
      logic        start_pass;
      logic        div_start;
      div_sel_type div_sel;
      logic        store_rows;
      logic        store_pitch;
      logic        check_rows;
      logic        store_ch;
      logic        mul_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic count_zero;
      logic active;
      logic div_busy;
      logic out_free;
   } status_type;

   // Smallest c with c * c >= n, for n from 1 to 64.
   function automatic logic [3:0] ceil_sqrt(input logic [6:0] n);
      logic [3:0] c;
      c = 4'd1;
      for (int k = 1; k <= 7; k++) begin
         if (7'(k * k) < n) begin
            c = c + 4'd1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/ggtp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ggtp_pkg for the step count.
`default_nettype none
module ggtp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [6:0]  divisor,
   output logic             busy,
   output logic [15:0]      quotient,
   output logic [6:0]       remainder
);
   import ggtp_pkg::*;

   logic [4:0]  count_ff, count_in;
   logic [15:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  dsr_ff, dsr_in;
   logic [7:0]  trial;
   logic [7:0]  diff;

   assign trial = {rem_ff, quo_ff[15]};
   assign diff = trial - {1'b0, dsr_ff};

   always_comb begin
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (start) begin
         count_in = DivSteps;
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (count_ff != 5'd0) begin
         count_in = count_ff - 5'd1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[6:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[6:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = (count_ff != 5'd0);
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== sv/ggtp_ctrl.sv =====
// Controller state machine of the tile placer: sequences capture, divisions,
// offset products and the result load. Depends on ggtp_pkg.
`default_nettype none
module ggtp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ggtp_pkg::status_type  status,
   output ggtp_pkg::cmd_type          cmd
);
   import ggtp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.first && status.count_zero) begin
               cmd.clear_pass = 1'b1;
               state_in = ST_IDLE;
            end else if (status.first) begin
               cmd.start_pass = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel = DIV_ROWS;
               state_in = ST_ROWS;
            end else if (!status.active) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel = DIV_WIN;
               state_in = ST_WIN;
            end
         end
         ST_ROWS: begin
            if (!status.div_busy) begin
               cmd.store_rows = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel = DIV_PITCH;
               state_in = ST_PITCH;
            end
         end
         ST_PITCH: begin
            if (!status.div_busy) begin
               cmd.store_pitch = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel = DIV_WIN;
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            if (!status.div_busy) begin
               cmd.check_rows = 1'b1;
               state_in = ST_CH_GO;
            end
         end
         ST_CH_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DIV_CH;
            state_in = ST_CH;
         end
         ST_CH: begin
            if (!status.div_busy) begin
               cmd.store_ch = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/ggtp_dpath.sv =====
// Datapath of the tile placer: area registers, pass state, the shared divider,
// offset multipliers and the result register. Depends on ggtp_pkg and ggtp_div.
`default_nettype none
module ggtp_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ggtp_pkg::cmd_type                   cmd,
   output ggtp_pkg::status_type                     status,
   input  wire logic [6:0]                          req_window_count,
   input  wire logic [7:0]                          req_border_width,
   input  wire logic                                req_first_window,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [16:0]                              rsp_tile_x,
   output logic [16:0]                              rsp_tile_y,
   output logic [15:0]                              rsp_tile_width,
   output logic [15:0]                              rsp_tile_height,
   input  wire logic                                csr_write_enable,
   input  wire logic [ggtp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [15:0]                         csr_write_data
);
   import ggtp_pkg::*;

   logic [15:0] area_x_ff, area_y_ff, area_w_ff, area_h_ff;

   logic [6:0]  count_ff;
   logic [7:0]  border_ff;
   logic        first_ff;

   logic [6:0]  total_ff;
   logic [3:0]  cols_ff;
   logic [6:0]  rows_ff;
   logic [6:0]  rows_base_ff;
   logic [3:0]  thresh_ff;
   logic [6:0]  col_idx_ff, col_idx_in;
   logic [6:0]  row_idx_ff, row_idx_in;
   logic [6:0]  win_idx_ff;
   logic [15:0] pitch_ff;
   logic        wide_ff;
   logic [15:0] ch_ff;
   logic [16:0] off_col_ff, off_row_ff;

   logic        out_valid_ff;
   logic [16:0] tile_x_ff, tile_y_ff;
   logic [15:0] tile_w_ff, tile_h_ff;

   logic [6:0]  count_sat;
   logic [3:0]  cols_sqrt;
   logic        wide_now;
   logic [18:0] width_x5, height_x7;
   logic [15:0] div_dividend;
   logic [6:0]  div_divisor;
   logic        div_busy;
   logic [15:0] div_quotient;
   logic [6:0]  div_remainder;
   logic [7:0]  col_of_win;
   logic [22:0] prod_col, prod_row;
   logic [8:0]  border_x2;
   logic [15:0] w_src, h_src;
   logic [16:0] sum_x, sum_y;
   logic [6:0]  row_next;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         area_x_ff <= '0;
         area_y_ff <= '0;
         area_w_ff <= AreaWidthReset;
         area_h_ff <= AreaHeightReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AREA_X:      area_x_ff <= csr_write_data;
            CSR_AREA_Y:      area_y_ff <= csr_write_data;
            CSR_AREA_WIDTH:  area_w_ff <= csr_write_data;
            CSR_AREA_HEIGHT: area_h_ff <= csr_write_data;
            default:         area_x_ff <= area_x_ff;
         endcase
      end
   end

   assign count_sat = (count_ff > MaxWindows) ? MaxWindows : count_ff;
   assign cols_sqrt = ceil_sqrt(count_sat);
   assign width_x5 = {area_w_ff, 2'b00} + {3'b000, area_w_ff};
   assign height_x7 = {area_h_ff, 3'b000} - {3'b000, area_h_ff};
   assign wide_now = (width_x5 > height_x7);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_ROWS: begin
            div_dividend = {9'd0, count_sat};
            div_divisor = {3'd0, cols_sqrt};
         end
         DIV_PITCH: begin
            div_dividend = wide_ff ? area_w_ff : area_h_ff;
            div_divisor = {3'd0, cols_ff};
         end
         DIV_WIN: begin
            div_dividend = {9'd0, win_idx_ff};
            div_divisor = rows_ff;
         end
         DIV_CH: begin
            div_dividend = wide_ff ? area_h_ff : area_w_ff;
            div_divisor = rows_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor = 7'd1;
         end
      endcase
   end

   ggtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Column the current window falls in, counted from one.
   assign col_of_win = {1'b0, div_quotient[6:0]} + 8'd1;

   assign prod_col = {16'd0, col_idx_ff} * {7'd0, pitch_ff};
   assign prod_row = {16'd0, row_idx_ff} * {7'd0, ch_ff};

   assign border_x2 = {border_ff, 1'b0};
   assign w_src = wide_ff ? pitch_ff : ch_ff;
   assign h_src = wide_ff ? ch_ff : pitch_ff;
   assign sum_x = {1'b0, area_x_ff} + (wide_ff ? off_col_ff : off_row_ff);
   assign sum_y = {1'b0, area_y_ff} + (wide_ff ? off_row_ff : off_col_ff);

   always_comb begin
      row_next = row_idx_ff + 7'd1;
      row_idx_in = row_next;
      col_idx_in = col_idx_ff;
      if (row_next >= rows_ff) begin
         row_idx_in = '0;
         col_idx_in = col_idx_ff + 7'd1;
      end
   end

   // Captured request word.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         count_ff <= req_window_count;
         border_ff <= req_border_width;
         first_ff <= req_first_window;
      end
   end

   // Pass state.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_pass) begin
         total_ff <= '0;
         cols_ff <= '0;
         rows_ff <= '0;
         rows_base_ff <= '0;
         thresh_ff <= '0;
         col_idx_ff <= '0;
         row_idx_ff <= '0;
         win_idx_ff <= '0;
         pitch_ff <= '0;
         wide_ff <= 1'b0;
      end else begin
         if (cmd.start_pass) begin
            total_ff <= count_sat;
            cols_ff <= cols_sqrt;
            wide_ff <= wide_now;
            col_idx_ff <= '0;
            row_idx_ff <= '0;
            win_idx_ff <= '0;
         end
         if (cmd.store_rows) begin
            rows_ff <= div_quotient[6:0];
            rows_base_ff <= div_quotient[6:0];
            thresh_ff <= cols_ff - div_remainder[3:0];
         end
         if (cmd.store_pitch) begin
            pitch_ff <= div_quotient;
         end
         if (cmd.check_rows && (col_of_win > {4'd0, thresh_ff})) begin
            rows_ff <= rows_base_ff + 7'd1;
         end
         if (cmd.out_load) begin
            row_idx_ff <= row_idx_in;
            col_idx_ff <= col_idx_in;
            win_idx_ff <= win_idx_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_ch) begin
         ch_ff <= div_quotient;
      end
      if (cmd.mul_load) begin
         off_col_ff <= prod_col[16:0];
         off_row_ff <= prod_row[16:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         tile_x_ff <= sum_x;
         tile_y_ff <= sum_y;
         tile_w_ff <= (w_src > {7'd0, border_x2}) ? (w_src - {7'd0, border_x2}) : '0;
         tile_h_ff <= (h_src > {7'd0, border_x2}) ? (h_src - {7'd0, border_x2}) : '0;
      end
   end

   assign status.first = first_ff;
   assign status.count_zero = (count_sat == 7'd0);
   assign status.active = (cols_ff != 4'd0) && (rows_ff != 7'd0) && (total_ff != 7'd0);
   assign status.div_busy = div_busy;
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_tile_x = tile_x_ff;
   assign rsp_tile_y = tile_y_ff;
   assign rsp_tile_width = tile_w_ff;
   assign rsp_tile_height = tile_h_ff;

endmodule
`default_nettype wire

// ===== sv/gapless_grid_tile_placer_core.sv =====
// A window that continues a pass runs the divider twice before its word is loaded, a first
// window four times; requests are stalled until the last window's word has been loaded.
// That word is loaded only once the result register is empty or its result is being taken.
// A first window with a zero count, or a window outside a pass, gives no word.
// Reset is synchronous and active high; it ends any pass and loads the area defaults.
// Top level of the gapless grid tile placer; depends on ggtp_pkg, ggtp_ctrl and ggtp_dpath.
`default_nettype none
module gapless_grid_tile_placer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [6:0]                          req_window_count,
   input  wire logic [7:0]                          req_border_width,
   input  wire logic                                req_first_window,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [16:0]                              rsp_tile_x,
   output logic [16:0]                              rsp_tile_y,
   output logic [15:0]                              rsp_tile_width,
   output logic [15:0]                              rsp_tile_height,
   input  wire logic                                csr_write_enable,
   input  wire logic [ggtp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [15:0]                         csr_write_data
);
   import ggtp_pkg::*;

   cmd_type    cmd;
   status_type status;

   ggtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ggtp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_window_count (req_window_count),
      .req_border_width (req_border_width),
      .req_first_window (req_first_window),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_width   (rsp_tile_width),
      .rsp_tile_height  (rsp_tile_height),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule
`default_nettype wire

// ===== sv/ggtp_checker.sv =====
// Port-level checker for the tile placer and its bind to the top level.
// Depends on ggtp_pkg and the assertion macros header.
`default_nettype none
`include "gapless_grid_tile_placer_core_defines.svh"
module ggtp_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [6:0]                          req_window_count,
   input  wire logic [7:0]                          req_border_width,
   input  wire logic                                req_first_window,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [16:0]                         rsp_tile_x,
   input  wire logic [16:0]                         rsp_tile_y,
   input  wire logic [15:0]                         rsp_tile_width,
   input  wire logic [15:0]                         rsp_tile_height,
   input  wire logic                                csr_write_enable,
   input  wire logic [ggtp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [15:0]                         csr_write_data
);
   import ggtp_pkg::*;

   `GGTP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_tile_x) && $stable(rsp_tile_y)
      && $stable(rsp_tile_width) && $stable(rsp_tile_height))
   `GGTP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `GGTP_ASSERT_NXT(a_no_early_word, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))
   `GGTP_ASSERT_IMP(a_word_when_idle, clock, reset, $rose(rsp_valid), !req_stall)

endmodule

bind gapless_grid_tile_placer_core ggtp_checker u_checker (.*);
`default_nettype wire

// ===== test/gapless_grid_tile_placer_checker.sv =====
// Scoreboard for the gapless grid tile placer: it watches the request, response and CSR ports,
// predicts every tile placement and compares each response word with the oldest prediction.
// Depends on ggtp_pkg for the CSR indexes and the area reset values.
module gapless_grid_tile_placer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [6:0]                         req_window_count,
   input  logic [7:0]                         req_border_width,
   input  logic                               req_first_window,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [16:0]                        rsp_tile_x,
   input  logic [16:0]                        rsp_tile_y,
   input  logic [15:0]                        rsp_tile_width,
   input  logic [15:0]                        rsp_tile_height,
   input  logic                               csr_write_enable,
   input  logic [ggtp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]                        csr_write_data,
   output int                                 fail_count,
   output int                                 tiles_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ggtp_pkg::*;

   localparam int WindowLimit = 64;
   localparam int PrintLimit = 100;

   typedef struct packed {
      logic [16:0] x;
      logic [16:0] y;
      logic [15:0] width;
      logic [15:0] height;
   } tile_type;

   logic [15:0] org_x, org_y, span_w, span_h;
   logic [6:0]  pass_count, col_rows, grid_col, grid_row, placed;
   logic [3:0]  grid_cols;
   logic [15:0] pitch_latched;
   logic        landscape;

   tile_type expected_tiles[$];
   int       mismatches = 0;

   task automatic report_mismatch(input string what, input logic [16:0] got,
         input logic [16:0] want);
      if (mismatches < PrintLimit) begin
         $display("%0t ns: tile mismatch on %s, got %0d, want %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic bit place_window(input logic [6:0] count_in, input logic [7:0] border,
         input logic first, output tile_type tile);
      int unsigned n, cols, rows, idx, row_size, pitch, across, down, inner_w, inner_h;
      tile = '0;
      n = count_in;
      if (first) begin
         if (n > WindowLimit) begin
            n = WindowLimit;
         end
         if (n == 0) begin
            pass_count = '0;
            grid_cols = '0;
            col_rows = '0;
            grid_col = '0;
            grid_row = '0;
            placed = '0;
            pitch_latched = '0;
            landscape = 1'b0;
            return 1'b0;
         end
         cols = 1;
         while (cols * cols < n) begin
            cols++;
         end
         pass_count = 7'(n);
         grid_cols = 4'(cols);
         col_rows = 7'(n / cols);
         landscape = (5 * int'(span_w)) > (7 * int'(span_h));
         pitch_latched = 16'((landscape ? int'(span_w) : int'(span_h)) / cols);
         grid_col = '0;
         grid_row = '0;
         placed = '0;
      end
      if (grid_cols == 0 || col_rows == 0) begin
         return 1'b0;
      end
      n = pass_count;
      cols = grid_cols;
      rows = col_rows;
      idx = placed;
      // The last n mod cols columns carry one extra row.
      if (idx / rows + 1 > cols - n % cols) begin
         col_rows = 7'(n / cols + 1);
      end
      rows = col_rows;
      row_size = (landscape ? int'(span_h) : int'(span_w)) / rows;
      pitch = pitch_latched;
      across = landscape ? int'(grid_col) * pitch : int'(grid_row) * row_size;
      down = landscape ? int'(grid_row) * row_size : int'(grid_col) * pitch;
      inner_w = landscape ? pitch : row_size;
      inner_h = landscape ? row_size : pitch;
      inner_w = (inner_w > 2 * int'(border)) ? inner_w - 2 * int'(border) : 0;
      inner_h = (inner_h > 2 * int'(border)) ? inner_h - 2 * int'(border) : 0;
      tile.x = 17'(int'(org_x) + across);
      tile.y = 17'(int'(org_y) + down);
      tile.width = 16'(inner_w);
      tile.height = 16'(inner_h);
      grid_row = grid_row + 7'd1;
      if (grid_row >= col_rows) begin
         grid_row = '0;
         grid_col = grid_col + 7'd1;
      end
      placed = placed + 7'd1;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      tile_type predicted;
      tile_type want;
      if (reset) begin
         org_x = '0;
         org_y = '0;
         span_w = AreaWidthReset;
         span_h = AreaHeightReset;
         pass_count = '0;
         grid_cols = '0;
         col_rows = '0;
         grid_col = '0;
         grid_row = '0;
         placed = '0;
         pitch_latched = '0;
         landscape = 1'b0;
         expected_tiles.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AREA_X: org_x = csr_write_data;
               CSR_AREA_Y: org_y = csr_write_data;
               CSR_AREA_WIDTH: span_w = csr_write_data;
               CSR_AREA_HEIGHT: span_h = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (place_window(req_window_count, req_border_width, req_first_window,
                  predicted)) begin
               expected_tiles.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tiles.size() == 0) begin
               report_mismatch("an unexpected word, tile_x", rsp_tile_x, '0);
            end else begin
               want = expected_tiles.pop_front();
               if (rsp_tile_x !== want.x) begin
                  report_mismatch("tile_x", rsp_tile_x, want.x);
               end
               if (rsp_tile_y !== want.y) begin
                  report_mismatch("tile_y", rsp_tile_y, want.y);
               end
               if (rsp_tile_width !== want.width) begin
                  report_mismatch("tile_width", rsp_tile_width, want.width);
               end
               if (rsp_tile_height !== want.height) begin
                  report_mismatch("tile_height", rsp_tile_height, want.height);
               end
            end
         end
      end
      tiles_pending <= expected_tiles.size();
      fail_count <= mismatches;
   end

endmodule

// ===== test/tb_gapless_grid_tile_placer_core.sv =====
// Testbench top for gapless_grid_tile_placer_core: drives directed and random layout passes
// under several work areas and idle patterns, and gives the verdict.
// Depends on ggtp_pkg, the block itself and gapless_grid_tile_placer_checker.
module tb_gapless_grid_tile_placer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ggtp_pkg::*;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 100;
   localparam int WordsPerMode = 350;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [6:0]    req_window_count = '0;
   logic [7:0]    req_border_width = '0;
   logic          req_first_window = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [16:0]   rsp_tile_x;
   logic [16:0]   rsp_tile_y;
   logic [15:0]   rsp_tile_width;
   logic [15:0]   rsp_tile_height;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_AREA_X;
   logic [15:0]   csr_write_data = '0;

   int fail_count;
   int tiles_pending;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int counted_words = 0;
   bit pass_live = 1'b0;

   gapless_grid_tile_placer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_window_count (req_window_count),
      .req_border_width (req_border_width),
      .req_first_window (req_first_window),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_width   (rsp_tile_width),
      .rsp_tile_height  (rsp_tile_height),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gapless_grid_tile_placer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_window_count (req_window_count),
      .req_border_width (req_border_width),
      .req_first_window (req_first_window),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_width   (rsp_tile_width),
      .rsp_tile_height  (rsp_tile_height),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .tiles_pending    (tiles_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < sink_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("gapless_grid_tile_placer_core regression: fail");
         $finish;
      end
   end

   function automatic logic [7:0] rand_border();
      int pick;
      pick = $urandom_range(3);
      if (pick == 0) begin
         return 8'd0;
      end else if (pick == 1) begin
         return 8'($urandom_range(1, 8));
      end
      return 8'($urandom);
   endfunction

   // The valid line stays high between back-to-back words; this task drops it only for an idle gap.
   task automatic send_word(input logic [6:0] count, input logic [7:0] border,
         input logic first);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < src_idle_pct);
      end
      req_valid <= 1'b1;
      req_window_count <= count;
      req_border_width <= border;
      req_first_window <= first;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (first) begin
         pass_live = (count != 0);
      end
      if (pass_live) begin
         counted_words++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tiles_pending != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apply_area(input logic [15:0] x, input logic [15:0] y,
         input logic [15:0] w, input logic [15:0] h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_AREA_X;
      csr_write_data <= x;
      @(posedge clock);
      csr_index <= CSR_AREA_Y;
      csr_write_data <= y;
      @(posedge clock);
      csr_index <= CSR_AREA_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      csr_index <= CSR_AREA_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic pick_area(input int sel);
      int k;
      k = $urandom_range(1, 9362);
      case (sel)
         0: apply_area(16'd0, 16'd0, 16'd1920, 16'd1080);
         1: apply_area(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         2: apply_area(16'd0, 16'd0, 16'd1, 16'd1);
         3: apply_area(16'($urandom), 16'($urandom), 16'hFFFF, 16'd1);
         4: apply_area(16'($urandom), 16'($urandom), 16'd1, 16'hFFFF);
         // Aspect ratio right at the wide threshold, or one pixel either side of it.
         5: apply_area(16'($urandom), 16'($urandom), 16'(7 * k + $urandom_range(2) - 1),
               16'(5 * k));
         default: apply_area(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)));
      endcase
   endtask

   task automatic run_pass();
      int pick;
      int n;
      int tail;
      pick = $urandom_range(99);
      if (pick < 78) begin
         n = $urandom_range(1, 64);
         tail = n - 1;
         if ($urandom_range(14) == 0) begin
            tail += $urandom_range(1, 140);
         end
         send_word(7'(n), rand_border(), 1'b1);
         repeat (tail) send_word(7'($urandom), rand_border(), 1'b0);
      end else if (pick < 88) begin
         n = $urandom_range(2, 64);
         send_word(7'(n), rand_border(), 1'b1);
         repeat ($urandom_range(0, n - 2)) send_word(7'($urandom), rand_border(), 1'b0);
      end else if (pick < 94) begin
         send_word(7'd0, rand_border(), 1'b1);
         repeat ($urandom_range(1, 3)) send_word(7'($urandom), rand_border(), 1'b0);
      end else if (pick < 97) begin
         send_word(7'($urandom_range(65, 127)), rand_border(), 1'b1);
         repeat ($urandom_range(0, 70)) send_word(7'($urandom), rand_border(), 1'b0);
      end else begin
         repeat ($urandom_range(1, 3)) send_word(7'($urandom), rand_border(), 1'b0);
      end
   endtask

   initial begin : stimulus
      int segment;
      int goal;
      int segment_end;
      segment = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(7'd127, 8'd255, 1'b0);
      send_word(7'd0, 8'd0, 1'b1);
      send_word(7'd0, 8'd7, 1'b0);
      send_word(7'd1, 8'd0, 1'b1);
      send_word(7'd2, 8'd1, 1'b0);
      send_word(7'd127, 8'd255, 1'b1);
      send_word(7'd64, 8'd128, 1'b0);
      send_word(7'd5, 8'd3, 1'b1);
      repeat (5) send_word(7'h2A, 8'h55, 1'b0);
      send_word(7'd64, 8'd0, 1'b1);
      send_word(7'h55, 8'hAA, 1'b0);
      wait_drained();
      apply_area(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      send_word(7'd7, 8'd0, 1'b1);
      repeat (2) send_word(7'd0, 8'd1, 1'b0);
      wait_drained();
      apply_area(16'd0, 16'd0, 16'd1, 16'hFFFF);
      send_word(7'd10, 8'd255, 1'b1);
      repeat (2) send_word(7'd0, 8'd0, 1'b0);

      for (int mode = 0; mode < 3; mode++) begin
         src_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 64 : 0;
         sink_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 34 : 0;
         goal = counted_words + WordsPerMode;
         while (counted_words < goal) begin
            wait_drained();
            pick_area((segment < 7) ? segment : $urandom_range(6));
            segment++;
            segment_end = counted_words + $urandom_range(40, 120);
            while (counted_words < segment_end && counted_words < goal) begin
               run_pass();
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("gapless_grid_tile_placer_core regression: pass");
      end else begin
         $display("gapless_grid_tile_placer_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ggtp_pkg.sv
sv/ggtp_div.sv
sv/ggtp_ctrl.sv
sv/ggtp_dpath.sv
sv/gapless_grid_tile_placer_core.sv
sv/ggtp_checker.sv
test/gapless_grid_tile_placer_checker.sv
test/tb_gapless_grid_tile_placer_core.sv
